// ===== hw/rtl/lbs2d_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lbs2d_pkg;

  localparam int unsigned LBS_MAX_VERTICES = 65536;
  localparam int unsigned LBS_QDEPTH = 2;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic [16:0]        weight;
    logic signed [31:0] mat_a;
    logic signed [31:0] mat_b;
    logic signed [31:0] mat_c;
    logic signed [31:0] mat_d;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic               last_influence;
  } item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic [15:0]        vertex_index;
  } result_t;

  // Prepared influence held in the queue between front and back.
  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic [16:0]        weight;
    logic signed [31:0] mat_a;
    logic signed [31:0] mat_b;
    logic signed [31:0] mat_c;
    logic signed [31:0] mat_d;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic               last;
  } work_t;

  function automatic logic [31:0] sat32(input logic [49:0] v);
    logic [31:0] r;
    if (v[49:31] == {19{v[49]}}) begin
      r = v[31:0];
    end else if (v[49]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7fff_ffff;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lbs2d_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lbs2d_front (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  item_valid,
  output logic                 item_ready,
  input  lbs2d_pkg::item_t     item,
  output logic                 push_valid,
  input  wire                  push_ready,
  output lbs2d_pkg::work_t     push_data
);

  logic             fv;
  lbs2d_pkg::work_t fdata;
  lbs2d_pkg::work_t prep;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    logic [31:0] r;
    s = {a[31], a} + {b[31], b};
    if (s[32] == s[31]) begin
      r = s[31:0];
    end else if (s[32]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7fff_ffff;
    end
    return r;
  endfunction

  always_comb begin
    prep.vx      = sat_add32(item.pos_x, item.offset_x);
    prep.vy      = sat_add32(item.pos_y, item.offset_y);
    prep.weight  = item.weight;
    prep.mat_a   = item.mat_a;
    prep.mat_b   = item.mat_b;
    prep.mat_c   = item.mat_c;
    prep.mat_d   = item.mat_d;
    prep.trans_x = item.trans_x;
    prep.trans_y = item.trans_y;
    prep.last    = item.last_influence;
  end

  assign item_ready = !fv || push_ready;
  assign push_valid = fv;
  assign push_data  = fdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (item_valid && item_ready) begin
      fv <= 1'b1;
    end else if (push_ready) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      fdata <= prep;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lbs2d_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lbs2d_queue (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push_valid,
  output logic                 push_ready,
  input  lbs2d_pkg::work_t     push_data,
  output logic                 head_valid,
  input  wire                  pop,
  output lbs2d_pkg::work_t     head
);

  localparam int unsigned QD  = lbs2d_pkg::LBS_QDEPTH;
  localparam int unsigned PW  = (QD > 1) ? $clog2(QD) : 1;
  localparam int unsigned CW  = $clog2(QD + 1);

  lbs2d_pkg::work_t  mem [QD];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [CW-1:0]     count;
  logic              push;

  assign push_ready = (count != CW'(QD));
  assign head_valid = (count != '0);
  assign push       = push_valid && push_ready;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QD - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QD - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QD))
    else $error("Queue count exceeds its depth.");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("Queue popped while empty.");

endmodule

`default_nettype wire

// ===== hw/rtl/lbs2d_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lbs2d_back #(
  parameter int unsigned MAX_VERTICES = lbs2d_pkg::LBS_MAX_VERTICES
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  head_valid,
  input  lbs2d_pkg::work_t     head,
  output logic                 pop,
  output logic                 result_valid,
  input  wire                  result_ready,
  output lbs2d_pkg::result_t   result
);

  localparam int unsigned WRAP = (MAX_VERTICES < 65536) ? MAX_VERTICES : 65536;

  localparam logic [2:0] S_MUL_A = 3'd0;
  localparam logic [2:0] S_MUL_C = 3'd1;
  localparam logic [2:0] S_MUL_B = 3'd2;
  localparam logic [2:0] S_MUL_D = 3'd3;
  localparam logic [2:0] S_WX    = 3'd4;
  localparam logic [2:0] S_WY    = 3'd5;
  localparam logic [2:0] S_ACC_Y = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]         step;
  logic [2:0]         step_next;
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] prod;
  logic [48:0]        tacc;
  logic [31:0]        tx;
  logic [31:0]        ty;
  logic [63:0]        sum_x;
  logic [63:0]        sum_y;
  logic [15:0]        cnt;
  logic [16:0]        cnt_inc;
  logic [48:0]        tacc_start;
  logic [49:0]        tacc_end;
  logic               out_free;
  logic               out_load;

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] d);
    logic [64:0] s;
    logic [63:0] r;
    s = {a[63], a} + {d[63], d};
    if (s[64] == s[63]) begin
      r = s[63:0];
    end else if (s[64]) begin
      r = {1'b1, 63'd0};
    end else begin
      r = {1'b0, {63{1'b1}}};
    end
    return r;
  endfunction

  always_comb begin
    unique case (step)
      S_MUL_A: begin mul_a = head.vx; mul_b = head.mat_a; end
      S_MUL_C: begin mul_a = head.vy; mul_b = head.mat_c; end
      S_MUL_B: begin mul_a = head.vx; mul_b = head.mat_b; end
      S_MUL_D: begin mul_a = head.vy; mul_b = head.mat_d; end
      S_WX:    begin mul_a = $signed(tx); mul_b = $signed({15'd0, head.weight}); end
      S_WY:    begin mul_a = $signed(ty); mul_b = $signed({15'd0, head.weight}); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_comb begin
    if (step == S_MUL_C) begin
      tacc_start = {prod[63], prod[63:16]} + {{17{head.trans_x[31]}}, head.trans_x};
    end else begin
      tacc_start = {prod[63], prod[63:16]} + {{17{head.trans_y[31]}}, head.trans_y};
    end
    tacc_end = {tacc[48], tacc} + {{2{prod[63]}}, prod[63:16]};
  end

  assign out_free = !result_valid || result_ready;
  assign out_load = (step == S_DONE) && head.last && out_free;
  assign pop      = (step == S_DONE) && (!head.last || out_free);
  assign cnt_inc  = {1'b0, cnt} + 17'd1;

  always_comb begin
    step_next = step;
    unique case (step)
      S_MUL_A: if (head_valid) step_next = S_MUL_C;
      S_DONE:  if (pop) step_next = S_MUL_A;
      default: step_next = step + 3'd1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= S_MUL_A;
      sum_x        <= '0;
      sum_y        <= '0;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      step <= step_next;
      if (step == S_WY) begin
        sum_x <= sat_add64(sum_x, prod);
      end
      if (step == S_ACC_Y) begin
        sum_y <= sat_add64(sum_y, prod);
      end
      if (out_load) begin
        sum_x        <= '0;
        sum_y        <= '0;
        cnt          <= (cnt_inc == 17'(WRAP)) ? '0 : cnt_inc[15:0];
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (step == S_MUL_C || step == S_MUL_D) begin
      tacc <= tacc_start;
    end
    if (step == S_MUL_B) begin
      tx <= lbs2d_pkg::sat32(tacc_end);
    end
    if (step == S_WX) begin
      ty <= lbs2d_pkg::sat32(tacc_end);
    end
    if (out_load) begin
      result.out_x        <= lbs2d_pkg::sat32({{2{sum_x[63]}}, sum_x[63:16]});
      result.out_y        <= lbs2d_pkg::sat32({{2{sum_y[63]}}, sum_y[63:16]});
      result.vertex_index <= cnt;
    end
  end

  a_head_held: assert property (@(posedge clk) disable iff (rst)
    (step != S_MUL_A) |-> head_valid)
    else $error("Back end is working without an item at the queue head.");

  a_sums_cleared: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (sum_x == '0) && (sum_y == '0))
    else $error("Accumulators not cleared after a vertex was finished.");

endmodule

`default_nettype wire

// ===== hw/rtl/linear_blend_skinning_2d.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Streamed 2D linear blend skinning in signed Q16.16. Each item beat is one
// joint influence; the beat marked last_influence yields one result beat with
// the saturated vertex position and its index, and clears the accumulators.
// The front stage forms position plus offset and feeds a two-entry queue, so
// up to three influences are taken at once, one per cycle until all three
// are held. The back end works on one influence at a time, its single shared
// 32x32 multiplier doing four matrix products and two weight products in
// turn. A result waits in an output register; only the next last beat stalls.
module linear_blend_skinning_2d #(
  parameter int unsigned MAX_VERTICES = lbs2d_pkg::LBS_MAX_VERTICES
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  item_valid,
  output logic                 item_ready,
  input  lbs2d_pkg::item_t     item,
  output logic                 result_valid,
  input  wire                  result_ready,
  output lbs2d_pkg::result_t   result
);

  logic             push_valid;
  logic             push_ready;
  lbs2d_pkg::work_t push_data;
  logic             head_valid;
  logic             pop;
  lbs2d_pkg::work_t head;

  lbs2d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  lbs2d_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .head_valid (head_valid),
    .pop        (pop),
    .head       (head)
  );

  lbs2d_back #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire

// ===== dv/tb_linear_blend_skinning_2d.sv =====
`timescale 1ns / 1ps

module tb_linear_blend_skinning_2d;

  localparam logic signed [31:0] QMAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] QMIN = 32'sh8000_0000;
  localparam logic signed [31:0] QONE = 32'sh0001_0000;
  localparam logic signed [31:0] QNEG = 32'shffff_ffff;
  localparam logic [16:0] W_ONE = 17'h1_0000;
  localparam logic [16:0] W_MAX = 17'h1_ffff;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 3000;
  localparam int TAIL_CYCLES = 64;

  typedef struct {
    lbs2d_pkg::item_t   it;
    bit                 typed;
    lbs2d_pkg::result_t val;
  } dir_row_t;

  logic               clk;
  logic               rst;
  logic               item_valid;
  logic               item_ready;
  lbs2d_pkg::item_t   item;
  logic               result_valid;
  logic               result_ready;
  lbs2d_pkg::result_t result;

  longint             blend_sum_x;
  longint             blend_sum_y;
  logic [15:0]        vertex_count;
  lbs2d_pkg::result_t vertex_exp_q[$];
  dir_row_t           dir_rows[$];

  bit                 cur_typed;
  lbs2d_pkg::result_t cur_typed_val;
  int      tx_idle_pct;
  int      rx_idle_pct;
  bit      hold_req;
  int      fail_count;
  int      items_sent;
  int      vertices_sent;
  int      quiet_cycles;

  linear_blend_skinning_2d u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #5 clk = ~clk;

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint add_sat64(input longint a, input longint d);
    longint s;
    s = a + d;
    if (a[63] == d[63] && s[63] != a[63]) begin
      return a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7fff_ffff_ffff_ffff;
    end
    return s;
  endfunction

  task automatic skin_predict(input lbs2d_pkg::item_t it, output bit done,
                              output lbs2d_pkg::result_t r);
    longint vx;
    longint vy;
    longint w;
    longint tx;
    longint ty;
    int     nxt;
    vx = clip32(longint'(it.pos_x) + longint'(it.offset_x));
    vy = clip32(longint'(it.pos_y) + longint'(it.offset_y));
    w = longint'(it.weight);
    tx = clip32(((vx * longint'(it.mat_a)) >>> 16) + ((vy * longint'(it.mat_c)) >>> 16)
                + longint'(it.trans_x));
    ty = clip32(((vx * longint'(it.mat_b)) >>> 16) + ((vy * longint'(it.mat_d)) >>> 16)
                + longint'(it.trans_y));
    blend_sum_x = add_sat64(blend_sum_x, tx * w);
    blend_sum_y = add_sat64(blend_sum_y, ty * w);
    done = it.last_influence;
    r = '0;
    if (done) begin
      r.out_x = 32'(clip32(blend_sum_x >>> 16));
      r.out_y = 32'(clip32(blend_sum_y >>> 16));
      r.vertex_index = vertex_count;
      blend_sum_x = 0;
      blend_sum_y = 0;
      nxt = int'(vertex_count) + 1;
      if (nxt >= int'(lbs2d_pkg::LBS_MAX_VERTICES) || nxt > 65535) begin
        nxt = 0;
      end
      vertex_count = nxt[15:0];
    end
  endtask

  function automatic lbs2d_pkg::item_t mk_item(
    input logic signed [31:0] px, py, ox, oy,
    input logic [16:0] w,
    input logic signed [31:0] a, b, c, d, tx, ty,
    input logic last
  );
    lbs2d_pkg::item_t it;
    it.pos_x = px;
    it.pos_y = py;
    it.offset_x = ox;
    it.offset_y = oy;
    it.weight = w;
    it.mat_a = a;
    it.mat_b = b;
    it.mat_c = c;
    it.mat_d = d;
    it.trans_x = tx;
    it.trans_y = ty;
    it.last_influence = last;
    return it;
  endfunction

  function automatic logic signed [31:0] rand_q();
    case ($urandom_range(0, 9))
      0: return QMIN;
      1: return QMAX;
      2, 3: return $urandom;
      4: return QONE;
      default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endcase
  endfunction

  function automatic logic [16:0] rand_weight();
    case ($urandom_range(0, 9))
      0: return 17'd0;
      1: return W_MAX;
      2: return W_ONE;
      3: return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic add_row(input lbs2d_pkg::item_t it, input bit typed,
                         input lbs2d_pkg::result_t val);
    dir_row_t row;
    row.it = it;
    row.typed = typed;
    row.val = val;
    dir_rows.push_back(row);
  endtask

  task automatic send_beat(input lbs2d_pkg::item_t it, input bit typed,
                           input lbs2d_pkg::result_t tv);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    cur_typed <= typed;
    cur_typed_val <= tv;
    @(posedge clk);
    while (!item_ready) begin
      @(posedge clk);
    end
    items_sent++;
    if (it.last_influence) begin
      vertices_sent++;
    end
    @(negedge clk);
  endtask

  task automatic send_vertex(input int len);
    lbs2d_pkg::item_t it;
    for (int i = 0; i < len; i++) begin
      it = mk_item(rand_q(), rand_q(), rand_q(), rand_q(), rand_weight(),
                   rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q(),
                   i == len - 1);
      send_beat(it, 1'b0, '0);
    end
  endtask

  task automatic random_phase(input int n_items);
    int start;
    int len;
    start = items_sent;
    while (items_sent - start < n_items) begin
      case ($urandom_range(0, 9))
        0, 1, 2: len = 1;
        9: len = $urandom_range(5, 12);
        default: len = $urandom_range(2, 4);
      endcase
      send_vertex(len);
    end
  endtask

  always @(posedge clk) begin : beat_monitor
    bit                 done;
    lbs2d_pkg::result_t pr;
    lbs2d_pkg::result_t want;
    if (!rst && result_valid && result_ready) begin
      if (vertex_exp_q.size() == 0) begin
        fail_count++;
        $display("%0t unexpected result beat: x=%h y=%h idx=%0d", $time,
                 result.out_x, result.out_y, result.vertex_index);
      end else begin
        want = vertex_exp_q.pop_front();
        if (result.out_x !== want.out_x || result.out_y !== want.out_y ||
            result.vertex_index !== want.vertex_index) begin
          fail_count++;
          $display("%0t mismatch: expected x=%h y=%h idx=%0d, got x=%h y=%h idx=%0d",
                   $time, want.out_x, want.out_y, want.vertex_index,
                   result.out_x, result.out_y, result.vertex_index);
        end
      end
    end
    if (!rst && item_valid && item_ready) begin
      skin_predict(item, done, pr);
      if (done) begin
        vertex_exp_q.push_back(cur_typed ? cur_typed_val : pr);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t no beat accepted for %0d cycles", $time, QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  // The receiver process owns result_ready, including the long hold-off.
  initial begin
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        result_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    cur_typed = 1'b0;
    cur_typed_val = '0;
    hold_req = 1'b0;
    fail_count = 0;
    items_sent = 0;
    vertices_sent = 0;
    quiet_cycles = 0;
    blend_sum_x = 0;
    blend_sum_y = 0;
    vertex_count = '0;
    tx_idle_pct = 35;
    rx_idle_pct = 55;

    add_row(mk_item(QMAX, QMAX, QMAX, QMAX, 17'd0, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, 1'b1),
            1'b1, lbs2d_pkg::result_t'{32'sd0, 32'sd0, 16'd0});
    add_row(mk_item(QONE, 32'shfffe_0000, 0, 0, W_ONE, QONE, 0, 0, QONE, 0, 0, 1'b1),
            1'b1, lbs2d_pkg::result_t'{32'sh0001_0000, 32'shfffe_0000, 16'd1});
    add_row(mk_item(QMAX, QMIN, QMAX, QMIN, W_ONE, QONE, 0, 0, QONE, 0, 0, 1'b1),
            1'b1, lbs2d_pkg::result_t'{QMAX, QMIN, 16'd2});
    add_row(mk_item(QMAX, QMAX, 0, 0, W_ONE, QMAX, QMIN, QMAX, QMIN, 0, 0, 1'b1),
            1'b1, lbs2d_pkg::result_t'{QMAX, QMIN, 16'd3});
    add_row(mk_item(QONE, QONE, 0, 0, W_MAX, QONE, 0, 0, QONE, 0, 0, 1'b1), 1'b0, '0);
    add_row(mk_item(0, 0, 0, 0, W_MAX, 0, 0, 0, 0, QMAX, QMIN, 1'b1),
            1'b1, lbs2d_pkg::result_t'{QMAX, QMIN, 16'd5});
    add_row(mk_item(32'sh0001_8000, 32'sh0002_0000, 0, 32'sh0000_1000, 17'h0_4000,
                    QONE, 0, 0, QONE, 32'sh0010_0000, 0, 1'b0), 1'b0, '0);
    add_row(mk_item(32'sh0001_8000, 32'sh0002_0000, 0, 32'sh0000_1000, 17'h0_8000,
                    32'sh0002_0000, 32'sh0000_8000, 32'shffff_8000, 32'sh0002_0000,
                    0, 32'shfff0_0000, 1'b0), 1'b0, '0);
    add_row(mk_item(32'sh0001_8000, 32'sh0002_0000, 0, 32'sh0000_1000, 17'h0_4000,
                    0, QONE, QONE, 0, 32'sh1234_5678, 32'sh8765_4321, 1'b1), 1'b0, '0);
    add_row(mk_item(32'sh0002_8000, 32'shfffe_c000, 32'shffff_4000, 32'sh0000_4000, 17'd1,
                    32'sh0000_b505, 32'sh0000_b505, 32'shffff_4afb, 32'sh0000_b505,
                    32'shfffd_0000, 32'sh0000_8000, 1'b1), 1'b0, '0);
    add_row(mk_item(QNEG, QNEG, QNEG, QNEG, W_MAX, QNEG, QNEG, QNEG, QNEG, QNEG, QNEG, 1'b1),
            1'b0, '0);
    add_row(mk_item(0, 0, 0, 0, 17'd0, 0, 0, 0, 0, 0, 0, 1'b0), 1'b0, '0);
    add_row(mk_item(32'sh0003_8000, 0, 0, 0, 17'h0_8000, QONE, 0, 0, QONE, 0, 32'sd1, 1'b1),
            1'b0, '0);
    add_row(mk_item(0, 0, 0, 0, 17'd0, 0, 0, 0, 0, 0, 0, 1'b1),
            1'b1, lbs2d_pkg::result_t'{32'sd0, 32'sd0, 16'd10});

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].val);
    end
    random_phase(170);

    tx_idle_pct = 55;
    rx_idle_pct = 35;
    random_phase(170);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req = 1'b1;
    random_phase(170);

    item_valid <= 1'b0;
    while (vertex_exp_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && vertex_exp_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
